FILE: hw/rtl/rof_pkg.sv
package rof_pkg;

  // Fixed field geometry
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned NUM_VALUES  = 5;
  localparam int unsigned POS_WIDTH   = 3;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [POS_WIDTH-1:0]          pos_t;

  // Request payload: five values, positions 0..4
  typedef struct packed {
    value_t value_a;
    value_t value_b;
    value_t value_c;
    value_t value_d;
    value_t value_e;
  } in_t;

  // Result payload: positions from largest to smallest, plus tie flag
  typedef struct packed {
    pos_t rank0_position;
    pos_t rank1_position;
    pos_t rank2_position;
    pos_t rank3_position;
    pos_t rank4_position;
    logic all_distinct;
  } out_t;

  // Pairwise precedence: prec[i][j] set when position i is ordered ahead of j
  typedef struct packed {
    logic [NUM_VALUES-1:0][NUM_VALUES-1:0] prec;
    logic                                  distinct;
  } cmp_t;

endpackage

FILE: hw/rtl/rof_cmp.sv
module rof_cmp (
  input  rof_pkg::in_t  data_i,
  output rof_pkg::cmp_t cmp_o
);

  rof_pkg::value_t vals [rof_pkg::NUM_VALUES];
  logic [rof_pkg::NUM_VALUES-1:0][rof_pkg::NUM_VALUES-1:0] eq;

  assign vals[0] = data_i.value_a;
  assign vals[1] = data_i.value_b;
  assign vals[2] = data_i.value_c;
  assign vals[3] = data_i.value_d;
  assign vals[4] = data_i.value_e;

  // Ten signed compares; ties go to the lower position
  always_comb begin
    cmp_o.prec = '0;
    eq         = '0;
    for (int i = 0; i < rof_pkg::NUM_VALUES; i++) begin
      for (int j = i + 1; j < rof_pkg::NUM_VALUES; j++) begin
        cmp_o.prec[i][j] = (vals[i] >= vals[j]);
        cmp_o.prec[j][i] = !(vals[i] >= vals[j]);
        eq[i][j]         = (vals[i] == vals[j]);
      end
    end
    cmp_o.distinct = ~|eq;
  end

endmodule

FILE: hw/rtl/rank_order_five_values_unit.sv
// Rank order of five signed values. Each request carries five two's complement
// values; the result lists their input positions from largest to smallest,
// with equal values ordered by lower position first, and all_distinct set when
// no two values are equal. The unit takes one request per clock while the
// result side is not stalling. A request passes three register stages
// (pairwise compare, rank count, position select); the first stage loads at
// the accepting edge, and the result is presented on the output from the
// position select register. Back-pressure on the result side stalls the
// stages in place; empty stages keep accepting.
module rank_order_five_values_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rof_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rof_pkg::out_t out_data_o
);

  localparam int unsigned N = rof_pkg::NUM_VALUES;

  logic [3:1] valid_q;
  logic [3:1] en;

  rof_pkg::cmp_t cmp_d, cmp_q;
  rof_pkg::pos_t [N-1:0] rank_d, rank_q;
  logic          dist_q;
  rof_pkg::out_t res_d, res_q;

  // Stage enables: a stage loads when it is empty or its content moves on
  assign en[3] = !valid_q[3] || out_ready_i;
  assign en[2] = !valid_q[2] || en[3];
  assign en[1] = !valid_q[1] || en[2];

  assign in_ready_o  = en[1];
  assign out_valid_o = valid_q[3];
  assign out_data_o  = res_q;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[1]) valid_q[1] <= in_valid_i;
      if (en[2]) valid_q[2] <= valid_q[1];
      if (en[3]) valid_q[3] <= valid_q[2];
    end
  end

  // Stage 1: pairwise compare
  rof_cmp u_cmp (
    .data_i (in_data_i),
    .cmp_o  (cmp_d)
  );

  always_ff @(posedge clk_i) begin
    if (en[1]) cmp_q <= cmp_d;
  end

  // Stage 2: rank of each position = number of positions ordered ahead of it
  always_comb begin
    for (int i = 0; i < N; i++) begin
      rank_d[i] = '0;
      for (int j = 0; j < N; j++) begin
        if (j != i) rank_d[i] = rank_d[i] + rof_pkg::pos_t'(cmp_q.prec[j][i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      rank_q <= rank_d;
      dist_q <= cmp_q.distinct;
    end
  end

  // Stage 3: invert the permutation into positions by rank
  always_comb begin
    rof_pkg::pos_t slot [N];
    for (int r = 0; r < N; r++) begin
      slot[r] = '0;
      for (int i = 0; i < N; i++) begin
        if (rank_q[i] == rof_pkg::pos_t'(r)) slot[r] = rof_pkg::pos_t'(i);
      end
    end
    res_d.rank0_position = slot[0];
    res_d.rank1_position = slot[1];
    res_d.rank2_position = slot[2];
    res_d.rank3_position = slot[3];
    res_d.rank4_position = slot[4];
    res_d.all_distinct   = dist_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) res_q <= res_d;
  end

  // Checks
  logic [N-1:0] pos_mask;
  always_comb begin
    pos_mask = '0;
    pos_mask[res_q.rank0_position] = 1'b1;
    pos_mask[res_q.rank1_position] = 1'b1;
    pos_mask[res_q.rank2_position] = 1'b1;
    pos_mask[res_q.rank3_position] = 1'b1;
    pos_mask[res_q.rank4_position] = 1'b1;
  end

  logic [N-1:0] rank_mask;
  always_comb begin
    rank_mask = '0;
    for (int i = 0; i < N; i++) begin
      if (rank_q[i] < rof_pkg::pos_t'(N)) rank_mask[rank_q[i]] = 1'b1;
    end
  end

  a_out_perm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pos_mask == '1))
    else $error("result positions are not a permutation");

  a_rank_perm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[2] |-> (rank_mask == '1))
    else $error("stage 2 ranks are not a permutation");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[2] && !en[3] |=> valid_q[2] && $stable(rank_q))
    else $error("stalled stage 2 lost its content");

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (valid_q == '1))
    else $error("request blocked with an empty stage");

endmodule
